### hw/rtl/relocatable_internal_ram_window_defines.svh
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RELOCATABLE_INTERNAL_RAM_WINDOW_DEFINES_SVH
`define RELOCATABLE_INTERNAL_RAM_WINDOW_DEFINES_SVH

// same-cycle implication
`define RIR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rir window check failed");

// next-cycle implication
`define RIR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rir window check failed");

`endif

### hw/rtl/rir_pkg.sv
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: package
// Types and fixed constants shared by the window decoder and its store.
// ----------------------------------------------------------------------------
package rir_pkg;

	localparam int AREA_SIZE = 256;
	localparam int IDX_W     = $clog2(AREA_SIZE);
	localparam int BANKS     = 8;
	localparam int BANK_W    = $clog2(BANKS);
	localparam int ROW_W     = IDX_W - BANK_W;
	localparam int ROWS      = AREA_SIZE / BANKS;
	localparam int ADDR_W    = 20;
	localparam int PAGE_SHIFT = 12;
	localparam int DATA_W    = 64;

	localparam logic [ADDR_W-1:0] BASE_PORT     = 20'hFFFFF;
	localparam logic [3:0]        WINDOW_NIBBLE = 4'hF;
	localparam logic [IDX_W-1:0]  BASE_INDEX    = 8'hFF;

	localparam logic [1:0] ROUTE_AREA = 2'd0;
	localparam logic [1:0] ROUTE_BASE = 2'd1;
	localparam logic [1:0] ROUTE_HOLE = 2'd2;
	localparam logic [1:0] ROUTE_BUS  = 2'd3;

	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;
	localparam logic [1:0] SIZE_QWORD = 2'd3;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] idx;
	} rd_req_t;

	typedef struct packed {
		logic             we0;
		logic [IDX_W-1:0] idx0;
		logic [7:0]       d0;
		logic             we1;
		logic [IDX_W-1:0] idx1;
		logic [7:0]       d1;
	} wr_req_t;

endpackage

### hw/rtl/rir_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/rir_store.sv
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: area store
// 256 bytes interleaved over eight byte banks, so eight consecutive bytes
// (wrapping) are read together. Per-byte valid bits give the 0xFF reset.
// ----------------------------------------------------------------------------
module rir_store (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rir_pkg::rd_req_t                       rd,
	input  rir_pkg::wr_req_t                       wr,
	output logic [rir_pkg::BANKS-1:0][7:0]         lanes
);

	logic [rir_pkg::AREA_SIZE-1:0]      valid_q;
	logic [rir_pkg::IDX_W-1:0]          rd_idx_s1;
	logic [rir_pkg::BANKS-1:0][7:0]     bank_q;

	genvar b;
	generate
		for (b = 0; b < rir_pkg::BANKS; b++) begin : g_bank
			localparam logic [rir_pkg::BANK_W-1:0] BID = rir_pkg::BANK_W'(b);
			logic                      hit0;
			logic                      hit1;
			logic                      bwe;
			logic [rir_pkg::ROW_W-1:0] bwaddr;
			logic [7:0]                bwdata;
			logic [rir_pkg::ROW_W-1:0] braddr;

			// banks below the start lane take the next row
			assign braddr = rd.idx[rir_pkg::IDX_W-1:rir_pkg::BANK_W] +
				{{(rir_pkg::ROW_W-1){1'b0}}, (BID < rd.idx[rir_pkg::BANK_W-1:0])};

			assign hit0   = wr.we0 && (wr.idx0[rir_pkg::BANK_W-1:0] == BID);
			assign hit1   = wr.we1 && (wr.idx1[rir_pkg::BANK_W-1:0] == BID);
			assign bwe    = hit0 || hit1;
			assign bwaddr = hit1 ? wr.idx1[rir_pkg::IDX_W-1:rir_pkg::BANK_W]
			                     : wr.idx0[rir_pkg::IDX_W-1:rir_pkg::BANK_W];
			assign bwdata = hit1 ? wr.d1 : wr.d0;

			rir_ram #(
				.WIDTH(8),
				.DEPTH(rir_pkg::ROWS)
			) u_ram (
				.clk  (clk),
				.we   (bwe),
				.waddr(bwaddr),
				.wdata(bwdata),
				.re   (rd.re),
				.raddr(braddr),
				.rdata(bank_q[b])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (rd.re) begin
			rd_idx_s1 <= rd.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr.we0) begin
				valid_q[wr.idx0] <= 1'b1;
			end
			if (wr.we1) begin
				valid_q[wr.idx1] <= 1'b1;
			end
		end
	end

	// lane k holds byte start+k
	always_comb begin
		logic [rir_pkg::IDX_W-1:0] e;
		for (int k = 0; k < rir_pkg::BANKS; k++) begin
			e = rd_idx_s1 + rir_pkg::IDX_W'(k);
			lanes[k] = valid_q[e] ? bank_q[e[rir_pkg::BANK_W-1:0]] : 8'hFF;
		end
	end

endmodule

### hw/rtl/relocatable_internal_ram_window.sv
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: top level
// Decodes each memory access against a relocatable 256-byte internal area.
// ----------------------------------------------------------------------------
// The banked store is read in the cycle the item is accepted, and the next
// cycle merges the bytes, decodes the route and writes back. The input stalls
// while an item sits in that decode step, so a read never overlaps a pending
// write-back; by this interlock a new item is not accepted until the previous
// one has left that step. The result waits in an output register, and the next
// item is accepted as soon as that register is free or being drained. The page
// base is byte 255, held also in a register; a byte access to 0xFFFFF reads or
// writes it. Word writes and multi-byte reads wrap within the area.
// bus_attached is written through the configuration channel, which is always
// ready; the user must write it only while idle: the block does not enforce it.
module relocatable_internal_ram_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        bus_attached,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [1:0]                  access_size,
	input  logic [rir_pkg::ADDR_W-1:0]  address,
	input  logic [15:0]                 write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  route,
	output logic [rir_pkg::DATA_W-1:0]  read_data
);

	logic                              accept;
	logic                              s1_valid_q;
	logic                              kind_s1;
	logic [1:0]                        size_s1;
	logic [rir_pkg::ADDR_W-1:0]        addr_s1;
	logic [15:0]                       wdata_s1;
	logic                              bus_q;
	logic [rir_pkg::IDX_W-1:0]         base_q;
	logic                              out_valid_q;
	logic [1:0]                        route_q;
	logic [rir_pkg::DATA_W-1:0]        rdata_q;

	rir_pkg::rd_req_t                  rd;
	rir_pkg::wr_req_t                  wr;
	logic [rir_pkg::BANKS-1:0][7:0]    lanes;

	logic [rir_pkg::IDX_W-1:0]         idx;
	logic                              is_base;
	logic                              in_page;
	logic                              in_win;
	logic                              is_write;
	logic [rir_pkg::BANKS-1:0]         lane_en;
	logic [rir_pkg::DATA_W-1:0]        area_data;
	logic [rir_pkg::DATA_W-1:0]        ones_data;
	logic [1:0]                        route_d;
	logic [rir_pkg::DATA_W-1:0]        rdata_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = s1_valid_q || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;

	assign rd.re  = accept;
	assign rd.idx = address[rir_pkg::IDX_W-1:0];

	rir_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.rd    (rd),
		.wr    (wr),
		.lanes (lanes)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			size_s1  <= access_size;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			bus_q      <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (cfg_valid) begin
				bus_q <= bus_attached;
			end
		end
	end

	// decode
	assign idx      = addr_s1[rir_pkg::IDX_W-1:0];
	assign is_write = (kind_s1 == rir_pkg::KIND_WRITE);
	assign is_base  = (size_s1 == rir_pkg::SIZE_BYTE) && (addr_s1 == rir_pkg::BASE_PORT);
	assign in_page  = (addr_s1[rir_pkg::ADDR_W-1:rir_pkg::PAGE_SHIFT] == base_q);
	assign in_win   = (addr_s1[rir_pkg::PAGE_SHIFT-1:rir_pkg::IDX_W] == rir_pkg::WINDOW_NIBBLE);

	always_comb begin
		unique case (size_s1)
			rir_pkg::SIZE_BYTE:  lane_en = 8'h01;
			rir_pkg::SIZE_WORD:  lane_en = 8'h03;
			rir_pkg::SIZE_DWORD: lane_en = 8'h0F;
			rir_pkg::SIZE_QWORD: lane_en = 8'hFF;
			default:             lane_en = 8'h00;
		endcase
	end

	// byte 255 lives in base_q
	always_comb begin
		logic [rir_pkg::IDX_W-1:0] e;
		logic [7:0]                bv;
		for (int k = 0; k < rir_pkg::BANKS; k++) begin
			e  = idx + rir_pkg::IDX_W'(k);
			bv = (e == rir_pkg::BASE_INDEX) ? base_q : lanes[k];
			area_data[k*8 +: 8] = lane_en[k] ? bv : 8'h00;
			ones_data[k*8 +: 8] = lane_en[k] ? 8'hFF : 8'h00;
		end
	end

	always_comb begin
		if (is_base) begin
			route_d = rir_pkg::ROUTE_BASE;
			rdata_d = {{(rir_pkg::DATA_W-rir_pkg::IDX_W){1'b0}}, base_q};
		end else if (in_page && in_win) begin
			route_d = rir_pkg::ROUTE_AREA;
			rdata_d = area_data;
		end else if (in_page) begin
			route_d = rir_pkg::ROUTE_HOLE;
			rdata_d = ones_data;
		end else begin
			route_d = rir_pkg::ROUTE_BUS;
			rdata_d = bus_q ? '0 : ones_data;
		end
		if (is_write) begin
			rdata_d = '0;
		end
	end

	// write-back
	always_comb begin
		wr.we0  = s1_valid_q && is_write &&
		          (is_base || (in_page && in_win &&
		           (size_s1 == rir_pkg::SIZE_BYTE || size_s1 == rir_pkg::SIZE_WORD)));
		wr.idx0 = is_base ? rir_pkg::BASE_INDEX : idx;
		wr.d0   = wdata_s1[7:0];
		wr.we1  = s1_valid_q && is_write && !is_base && in_page && in_win &&
		          (size_s1 == rir_pkg::SIZE_WORD);
		wr.idx1 = idx + rir_pkg::IDX_W'(1);
		wr.d1   = wdata_s1[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (wr.we0 && wr.idx0 == rir_pkg::BASE_INDEX) begin
			base_q <= wr.d0;
		end else if (wr.we1 && wr.idx1 == rir_pkg::BASE_INDEX) begin
			base_q <= wr.d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			route_q <= route_d;
			rdata_q <= rdata_d;
		end
	end

	assign out_valid = out_valid_q;
	assign route     = route_q;
	assign read_data = rdata_q;

endmodule

### hw/rtl/rir_checker.sv
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: port checker
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "relocatable_internal_ram_window_defines.svh"

module rir_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  route,
	input logic [rir_pkg::DATA_W-1:0]  read_data
);

	`RIR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(route) && $stable(read_data))
	`RIR_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)
	`RIR_ASSERT_IMP(a_base_byte, out_valid && route == rir_pkg::ROUTE_BASE, read_data[63:8] == 56'd0)
	`RIR_ASSERT_IMP(a_hole_ones, out_valid && route == rir_pkg::ROUTE_HOLE, read_data == 64'd0 || read_data == 64'hFF || read_data == 64'hFFFF || read_data == 64'hFFFF_FFFF || read_data == 64'hFFFF_FFFF_FFFF_FFFF)
	`RIR_ASSERT_IMP(a_bus_ones, out_valid && route == rir_pkg::ROUTE_BUS && read_data != 64'd0, read_data == 64'hFF || read_data == 64'hFFFF || read_data == 64'hFFFF_FFFF || read_data == 64'hFFFF_FFFF_FFFF_FFFF)

endmodule

bind relocatable_internal_ram_window rir_checker u_rir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.route    (route),
	.read_data(read_data)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocatable internal RAM window: testbench
// Drives memory accesses with random gaps and output stalls, predicts route
// and read data per item from a private copy of the 256-byte area, and checks
// each returned item in order. bus_attached is toggled between phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 165;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic                         bus_attached;
	logic                         in_valid;
	logic                         in_stall;
	logic                         kind;
	logic [1:0]                   access_size;
	logic [rir_pkg::ADDR_W-1:0]   address;
	logic [15:0]                  write_data;
	logic                         out_valid;
	logic                         out_stall;
	logic [1:0]                   route;
	logic [rir_pkg::DATA_W-1:0]   read_data;

	int cycle_count = 0;
	int in_gap_max  = 19;
	int stall_max   = 19;

	class window_scoreboard;
		typedef struct packed {
			logic [1:0]                 route;
			logic [rir_pkg::DATA_W-1:0] data;
		} reply_t;

		logic [7:0] area [rir_pkg::AREA_SIZE];
		logic       bus_on;
		reply_t     awaited_replies [$];
		int         mismatches;

		function new();
			foreach (area[i]) area[i] = 8'hFF;
			area[rir_pkg::BASE_INDEX] = 8'h00;
			bus_on = 1'b0;
			mismatches = 0;
		endfunction

		function void note_access(logic k, logic [1:0] sz, logic [rir_pkg::ADDR_W-1:0] a,
				logic [15:0] wd);
			reply_t     r;
			logic [7:0] idx;
			logic [7:0] pos;
			int         n;
			r.route = rir_pkg::ROUTE_BUS;
			r.data = '0;
			n = 1 << sz;
			if (sz == rir_pkg::SIZE_BYTE && a == rir_pkg::BASE_PORT) begin
				r.route = rir_pkg::ROUTE_BASE;
				if (k == rir_pkg::KIND_WRITE)
					area[rir_pkg::BASE_INDEX] = wd[7:0];
				else
					r.data[7:0] = area[rir_pkg::BASE_INDEX];
			end else if (a[rir_pkg::ADDR_W-1:rir_pkg::PAGE_SHIFT] ==
					area[rir_pkg::BASE_INDEX]) begin
				if (a[11:8] == rir_pkg::WINDOW_NIBBLE) begin
					r.route = rir_pkg::ROUTE_AREA;
					idx = a[7:0];
					if (k == rir_pkg::KIND_WRITE) begin
						if (sz == rir_pkg::SIZE_BYTE) begin
							area[idx] = wd[7:0];
						end else if (sz == rir_pkg::SIZE_WORD) begin
							area[idx] = wd[7:0];
							pos = idx + 8'd1;
							area[pos] = wd[15:8];
						end
					end else begin
						for (int i = 0; i < n; i++) begin
							pos = idx + i[7:0];
							r.data[8*i +: 8] = area[pos];
						end
					end
				end else begin
					r.route = rir_pkg::ROUTE_HOLE;
					if (k == rir_pkg::KIND_READ)
						for (int i = 0; i < n; i++) r.data[8*i +: 8] = 8'hFF;
				end
			end else begin
				if (k == rir_pkg::KIND_READ && !bus_on)
					for (int i = 0; i < n; i++) r.data[8*i +: 8] = 8'hFF;
			end
			awaited_replies.push_back(r);
		endfunction

		function void check_reply(logic [1:0] got_route,
				logic [rir_pkg::DATA_W-1:0] got_data);
			reply_t e;
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: route %0d data %h", got_route, got_data);
				return;
			end
			e = awaited_replies.pop_front();
			if (got_route !== e.route || got_data !== e.data) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: route exp %0d got %0d, data exp %h got %h",
						e.route, got_route, e.data, got_data);
			end
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction
	endclass

	window_scoreboard sb;

	relocatable_internal_ram_window dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.bus_attached (bus_attached),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.access_size  (access_size),
		.address      (address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.route        (route),
		.read_data    (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL relocatable_internal_ram_window");
		$finish;
	end

	// called just after a rising edge; returns at the edge that accepts the item
	task automatic drive_item(logic k, logic [1:0] sz, logic [rir_pkg::ADDR_W-1:0] a,
			logic [15:0] wd);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		access_size <= sz;
		address     <= a;
		write_data  <= wd;
		do @(posedge clk); while (in_stall);
		sb.note_access(k, sz, a, wd);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_bus(logic v);
		cfg_valid    <= 1'b1;
		bus_attached <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.bus_on = v;
	endtask

	task automatic random_access();
		int                         r;
		logic [7:0]                 pg;
		logic                       k;
		logic [1:0]                 sz;
		logic [rir_pkg::ADDR_W-1:0] a;
		logic [15:0]                wd;
		logic [3:0]                 nib;
		r   = $urandom_range(0, 99);
		pg  = sb.area[rir_pkg::BASE_INDEX];
		k   = 1'($urandom_range(0, 1));
		sz  = 2'($urandom_range(0, 3));
		wd  = 16'($urandom_range(0, 16'hFFFF));
		a   = 20'($urandom_range(0, 20'hFFFFF));
		nib = 4'($urandom_range(0, 14));
		if (r < 50) begin
			a = {pg, rir_pkg::WINDOW_NIBBLE, a[7:0]};
		end else if (r < 62) begin
			a = {pg, nib, a[7:0]};
		end else if (r < 72) begin
			// relocation through the base port, often to the page extremes
			sz = rir_pkg::SIZE_BYTE;
			a  = rir_pkg::BASE_PORT;
			if (r < 65)
				wd[7:0] = 8'hFF;
			else if (r < 67)
				wd[7:0] = 8'h00;
		end else if (r < 80) begin
			a = rir_pkg::BASE_PORT;
		end
		drive_item(k, sz, a, wd);
	endtask

	initial begin : result_sink
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, stall_max);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			sb.check_reply(route, read_data);
		end
	end

	initial begin
		sb = new();
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		bus_attached <= 1'b0;
		in_valid     <= 1'b0;
		kind         <= rir_pkg::KIND_READ;
		access_size  <= rir_pkg::SIZE_BYTE;
		address      <= '0;
		write_data   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		set_bus(1'b0);

		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_BYTE,  rir_pkg::BASE_PORT, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h00F00, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h00FF9, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_WORD,  20'h00F10, 16'hBEEF);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_DWORD, 20'h00F0F, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_BYTE,  20'h00F20, 16'hAB5A);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_WORD,  20'h00F20, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_DWORD, 20'h00F30, 16'h1234);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_QWORD, 20'h00F31, 16'hFFFF);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h00F30, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_BYTE,  20'h00000, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_WORD,  20'h00EFF, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_WORD,  20'h00E00, 16'h5555);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_DWORD, 20'h00E00, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h12345, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_BYTE,  20'h80000, 16'hFFFF);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_WORD,  20'h00FFF, 16'h0200);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_WORD,  20'h00FFF, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_BYTE,  rir_pkg::BASE_PORT, 16'h00FF);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_WORD,  rir_pkg::BASE_PORT, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, rir_pkg::BASE_PORT, 16'h0000);
		drive_item(rir_pkg::KIND_WRITE, rir_pkg::SIZE_WORD,  20'hFFFFE, 16'h0001);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_BYTE,  rir_pkg::BASE_PORT, 16'h0000);
		in_valid <= 1'b0;
		wait_drained();

		set_bus(1'b1);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h55555, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_BYTE,  20'hAAAAA, 16'h0000);
		drive_item(rir_pkg::KIND_READ,  rir_pkg::SIZE_QWORD, 20'h00700, 16'h0000);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			set_bus(p[0]);
			repeat (PHASE_ITEMS) random_access();
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS relocatable_internal_ram_window");
		else
			$display("FAIL relocatable_internal_ram_window");
		$finish;
	end
endmodule
